>>> rtl/ibus_frame_receiver_top_defines.svh
// Assertion helpers used by the RTL top; clocked on clk, disabled in reset.
`ifndef IBUS_FRAME_RECEIVER_TOP_DEFINES_SVH
`define IBUS_FRAME_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication.
`define IFR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ifr assertion failed");

// Next-cycle implication.
`define IFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ifr assertion failed");

`endif

>>> rtl/ifr_pkg.sv
package ifr_pkg;

  // Result kinds, carried on m_tuser
  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_OK       = 3'd1,
    KIND_BAD      = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_OVERFLOW = 3'd4
  } kind_t;

  // Input request kinds, carried on s_tuser
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Header byte positions within a frame
  localparam logic [7:0] POS_SRC = 8'd0;
  localparam logic [7:0] POS_LEN = 8'd1;
  localparam logic [7:0] POS_DST = 8'd2;

  localparam logic [7:0] HDR_BYTES     = 8'd3;
  localparam logic [7:0] MIN_END_COUNT = 8'd4;
  localparam logic [7:0] LEN_ADJUST    = 8'd2;
  localparam logic [7:0] COUNT_MAX     = 8'hFF;
  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // Deframer state
  typedef struct packed {
    logic [7:0] byte_count;
    logic [7:0] running_xor;
    logic [7:0] frame_src;
    logic [7:0] frame_len_field;
    logic [7:0] frame_dst;
    logic [7:0] idle_ticks;
  } frame_state_t;

  // One result request
  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] data_len;
    logic [7:0] data_byte;
    logic [7:0] data_index;
  } frame_result_t;

endpackage

>>> rtl/ifr_frame_logic.sv
module ifr_frame_logic (
  input  ifr_pkg::frame_state_t  st,
  input  logic                   cmd,
  input  logic [7:0]             rx_byte,
  input  logic [7:0]             idle_timeout,
  output ifr_pkg::frame_state_t  st_next,
  output ifr_pkg::frame_result_t res
);
  import ifr_pkg::*;

  logic [7:0] ticks_inc;
  logic       ovf;
  logic [7:0] cnt;
  logic [7:0] xor_cur;
  logic       frame_end;

  assign ticks_inc = (st.idle_ticks == COUNT_MAX) ? COUNT_MAX : st.idle_ticks + 8'd1;
  // overflow: the incoming byte restarts a frame at position zero
  assign ovf       = (st.byte_count == COUNT_MAX);
  assign cnt       = ovf ? 8'd0 : st.byte_count;
  assign xor_cur   = ovf ? 8'd0 : st.running_xor;
  assign frame_end = (cnt >= MIN_END_COUNT) && (st.frame_len_field == cnt - 8'd1);

  // next state and result for one request
  always_comb begin
    st_next        = st;
    res.valid      = 1'b0;
    res.kind       = KIND_DATA;
    res.src        = st.frame_src;
    res.dst        = st.frame_dst;
    res.data_len   = st.frame_len_field - LEN_ADJUST;
    res.data_byte  = 8'd0;
    res.data_index = 8'd0;
    if (cmd == CMD_TICK) begin
      st_next.idle_ticks = ticks_inc;
      if ((st.byte_count != 8'd0) && (ticks_inc > idle_timeout)) begin
        res.valid           = 1'b1;
        res.kind            = KIND_TIMEOUT;
        st_next.byte_count  = 8'd0;
        st_next.running_xor = 8'd0;
      end
    end else begin
      st_next.idle_ticks = 8'd0;
      if (ovf) begin
        res.valid = 1'b1;
        res.kind  = KIND_OVERFLOW;
      end
      if (frame_end) begin
        // checksum byte closes the frame
        res.valid           = 1'b1;
        res.kind            = (rx_byte == xor_cur) ? KIND_OK : KIND_BAD;
        st_next.byte_count  = 8'd0;
        st_next.running_xor = 8'd0;
      end else begin
        case (cnt)
          POS_SRC: st_next.frame_src       = rx_byte;
          POS_LEN: st_next.frame_len_field = rx_byte;
          POS_DST: st_next.frame_dst       = rx_byte;
          default: begin
            res.valid      = 1'b1;
            res.kind       = KIND_DATA;
            res.data_byte  = rx_byte;
            res.data_index = cnt - HDR_BYTES;
          end
        endcase
        st_next.running_xor = xor_cur ^ rx_byte;
        st_next.byte_count  = cnt + 8'd1;
      end
    end
  end

endmodule

>>> rtl/ibus_frame_receiver_top.sv
// Bus frame receiver: deframes source, length, destination, data bytes and an
// XOR checksum from a byte stream.
// Input channel s_*: one request per received byte (s_tuser = 0, byte in
// s_tdata) or per millisecond tick (s_tuser = 1).
// Output channel m_*: one request per data byte, per closed frame (ok or bad
// checksum) and per aborted frame (timeout or overflow); header bytes and
// plain ticks give none.
// Output: m_* is registered; a result appears in the cycle after its input is accepted.
// Throughput: one input per cycle while the output is not stalled, set by the single
// output register; the state update is one pass of small logic.
// Stall: s_tready = !m_tvalid || m_tready, so while a result waits unread the
// block accepts no new input; it resumes in the cycle the result is taken.
// cfg_we/cfg_wdata set the idle timeout; write only while idle.
// Reset (rst, synchronous): frame state and idle count clear, idle timeout
// returns to 10, output register empties.
module ibus_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  input  logic        s_tuser,   // cmd[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // src[7:0], dst[15:8], data_len[23:16],
                                 // data_byte[31:24], data_index[39:32]
  output logic [2:0]  m_tuser,   // kind[2:0]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);
  import ifr_pkg::*;

  `include "ibus_frame_receiver_top_defines.svh"

  frame_state_t  st;
  frame_state_t  st_next;
  frame_result_t res;
  frame_result_t res_q;
  logic [7:0]    idle_timeout;
  logic          s_acc;

  assign s_tready = !m_tvalid || m_tready;
  assign s_acc    = s_tvalid && s_tready;

  ifr_frame_logic u_logic (
    .st           (st),
    .cmd          (s_tuser),
    .rx_byte      (s_tdata),
    .idle_timeout (idle_timeout),
    .st_next      (st_next),
    .res          (res)
  );

  // state, config and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= '0;
      idle_timeout <= TIMEOUT_RESET;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        idle_timeout <= cfg_wdata;
      end
      if (s_acc) begin
        st <= st_next;
      end
      if (s_tready) begin
        m_tvalid <= s_acc && res.valid;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_acc && res.valid) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.data_index, res_q.data_byte, res_q.data_len,
                    res_q.dst, res_q.src};
  assign m_tuser = res_q.kind;

  // checks
  `IFR_ASSERT_NOW(a_data_after_header,
                  s_acc && res.valid && (res.kind == KIND_DATA),
                  st.byte_count >= HDR_BYTES)
  `IFR_ASSERT_NEXT(a_byte_clears_idle, s_acc && (s_tuser == CMD_BYTE),
                   st.idle_ticks == 8'd0)
  `IFR_ASSERT_NEXT(a_abort_clears_count,
                   s_acc && res.valid && (res.kind == KIND_TIMEOUT),
                   (st.byte_count == 8'd0) && (st.running_xor == 8'd0))
  `IFR_ASSERT_NOW(a_nondata_zero_fields,
                  m_tvalid && (m_tuser != KIND_DATA),
                  m_tdata[39:24] == 16'd0)

endmodule

>>> tb/tb_ibus_frame_receiver_top.sv
module tb_ibus_frame_receiver_top;
  import ifr_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int RESET_TICKS = 4;
  localparam int HOLD_AT     = 100;   // requests in before the long receiver stall
  localparam int HOLD_LEN    = 150;
  localparam int SHOW_MAX    = 30;    // cap on printed mismatches

  // One pending input request
  typedef struct {
    logic       cmd;
    logic [7:0] rx_byte;
    bit         drain_first;  // hold this one back until every result is in
  } bus_req_t;

  // One expected output request
  typedef struct {
    kind_t      kind;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] data_len;
    logic [7:0] data_byte;
    logic [7:0] data_index;
  } frame_expect_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // rx_byte[7:0]
  logic        s_tuser = 1'b0;   // cmd[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // src, dst, data_len, data_byte, data_index
  logic [2:0]  m_tuser;          // kind[2:0]
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = 8'd0;

  bus_req_t      pend_q[$];
  bus_req_t      drv_req;
  frame_expect_t expected_results[$];
  frame_expect_t got_exp;

  // Deframer state as predicted
  logic [7:0] frm_count, frm_xor, hdr_src, hdr_len, hdr_dst, tick_count;
  logic [7:0] idle_limit;

  int  fail_count = 0;
  int  owed = 0;          // expectations outstanding after the last edge
  int  items_in = 0;      // input requests accepted
  int  planned = 0;       // input requests queued by the stimulus
  int  timeout_now;       // timeout as the stimulus plans around it
  int  send_idle_pct = 33;
  int  recv_idle_pct = 58;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  next_drains = 1'b0;

  ibus_frame_receiver_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Queue a result with the header registers as they stand
  task automatic note_result(input kind_t k, input logic [7:0] b, input logic [7:0] idx);
    frame_expect_t e;
    e.kind       = k;
    e.src        = hdr_src;
    e.dst        = hdr_dst;
    e.data_len   = hdr_len - LEN_ADJUST;
    e.data_byte  = b;
    e.data_index = idx;
    expected_results.push_back(e);
  endtask

  // Advance the predicted deframer by one accepted request
  task automatic deframe_predict(input logic cmd, input logic [7:0] c);
    if (cmd == CMD_TICK) begin
      if (tick_count != COUNT_MAX) tick_count = tick_count + 8'd1;
      if (frm_count != 8'd0 && tick_count > idle_limit) begin
        note_result(KIND_TIMEOUT, 8'd0, 8'd0);
        frm_count = 8'd0;
        frm_xor   = 8'd0;
      end
    end else begin
      tick_count = 8'd0;
      // a full count drops the frame; this byte opens the next one
      if (frm_count == COUNT_MAX) begin
        note_result(KIND_OVERFLOW, 8'd0, 8'd0);
        frm_count = 8'd0;
        frm_xor   = 8'd0;
      end
      if (frm_count >= MIN_END_COUNT && hdr_len == frm_count - 8'd1) begin
        note_result((c == frm_xor) ? KIND_OK : KIND_BAD, 8'd0, 8'd0);
        frm_count = 8'd0;
        frm_xor   = 8'd0;
      end else begin
        case (frm_count)
          POS_SRC: hdr_src = c;
          POS_LEN: hdr_len = c;
          POS_DST: hdr_dst = c;
          default: note_result(KIND_DATA, c, frm_count - HDR_BYTES);
        endcase
        frm_xor   = frm_xor ^ c;
        frm_count = frm_count + 8'd1;
      end
    end
  endtask

  // Driver: offers the next pending request
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          (!pend_q[0].drain_first || (owed == 0 && !s_tvalid && !m_tvalid))) begin
        drv_req = pend_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= drv_req.rx_byte;
        s_tuser  <= drv_req.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && items_in >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Monitor: check results in order, predict from accepted requests
  always @(posedge clk) begin
    if (rst) begin
      frm_count  = 8'd0;
      frm_xor    = 8'd0;
      hdr_src    = 8'd0;
      hdr_len    = 8'd0;
      hdr_dst    = 8'd0;
      tick_count = 8'd0;
      idle_limit = TIMEOUT_RESET;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= SHOW_MAX)
            $display("%0t: unexpected result, expected none, got kind %0d src %h dst %h",
                     $time, m_tuser, m_tdata[7:0], m_tdata[15:8],
                     " len %h byte %h idx %h", m_tdata[23:16], m_tdata[31:24],
                     m_tdata[39:32]);
        end else begin
          got_exp = expected_results.pop_front();
          if (m_tuser !== got_exp.kind || m_tdata[7:0] !== got_exp.src ||
              m_tdata[15:8] !== got_exp.dst || m_tdata[23:16] !== got_exp.data_len ||
              m_tdata[31:24] !== got_exp.data_byte ||
              m_tdata[39:32] !== got_exp.data_index) begin
            fail_count++;
            if (fail_count <= SHOW_MAX)
              $display("%0t: expected kind %0d src %h dst %h len %h byte %h idx %h,",
                       $time, got_exp.kind, got_exp.src, got_exp.dst, got_exp.data_len,
                       got_exp.data_byte, got_exp.data_index,
                       " got kind %0d src %h dst %h len %h byte %h idx %h",
                       m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                       m_tdata[31:24], m_tdata[39:32]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        deframe_predict(s_tuser, s_tdata);
        items_in <= items_in + 1;
      end
      owed <= expected_results.size();
    end
  end

  task automatic add_item(input logic cmd, input logic [7:0] b);
    bus_req_t r;
    r.cmd         = cmd;
    r.rx_byte     = b;
    r.drain_first = next_drains;
    next_drains   = 1'b0;
    pend_q.push_back(r);
    planned++;
  endtask

  task automatic add_ticks(input int n);
    repeat (n) add_item(CMD_TICK, 8'($urandom));
  endtask

  // A few ticks that stay within the timeout
  task automatic maybe_ticks(input int pct);
    if ($urandom_range(0, 99) < pct)
      add_ticks($urandom_range(1, (timeout_now < 3) ? timeout_now : 3));
  endtask

  // Well-formed frame with random content
  task automatic add_frame(input logic [7:0] len_field, input bit good_ck, input int tick_pct);
    logic [7:0] ck;
    logic [7:0] b;
    int         i;
    b = 8'($urandom);
    add_item(CMD_BYTE, b);
    ck = b ^ len_field;
    add_item(CMD_BYTE, len_field);
    b = 8'($urandom);
    add_item(CMD_BYTE, b);
    ck = ck ^ b;
    for (i = 0; i < int'(len_field) - 2; i++) begin
      maybe_ticks(tick_pct);
      b = 8'($urandom);
      add_item(CMD_BYTE, b);
      ck = ck ^ b;
    end
    maybe_ticks(tick_pct);
    add_item(CMD_BYTE, good_ck ? ck : ck ^ 8'($urandom_range(1, 255)));
  endtask

  // Length below three: the frame runs to the full count, then a clean frame
  task automatic add_overflow_run();
    logic [7:0] s, d, x;
    add_item(CMD_BYTE, 8'($urandom));
    add_item(CMD_BYTE, 8'($urandom_range(0, 2)));
    add_item(CMD_BYTE, 8'($urandom));
    repeat (252) add_item(CMD_BYTE, 8'($urandom));
    s = 8'($urandom);
    d = 8'($urandom);
    x = 8'($urandom);
    add_item(CMD_BYTE, s);
    add_item(CMD_BYTE, HDR_BYTES);
    add_item(CMD_BYTE, d);
    add_item(CMD_BYTE, x);
    add_item(CMD_BYTE, s ^ HDR_BYTES ^ d ^ x);
  endtask

  // Mostly frames; some noise and timed-out partial frames while the timeout is short
  task automatic add_random_traffic(input int n);
    int stop;
    int r;
    stop = planned + n;
    while (planned < stop) begin
      r = $urandom_range(0, 99);
      if (r < 8 && timeout_now < 20) begin
        repeat ($urandom_range(1, 4)) add_item(1'($urandom_range(0, 1)), 8'($urandom));
        add_ticks(timeout_now + 1);
      end else if (r < 18 && timeout_now < 20) begin
        repeat ($urandom_range(1, 6)) add_item(CMD_BYTE, 8'($urandom));
        add_ticks(timeout_now + 1 + $urandom_range(0, 2));
      end else begin
        add_frame(8'(($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(3, 10)),
                  $urandom_range(0, 99) >= 20, 12);
      end
    end
  endtask

  // Wait until nothing is in flight
  task automatic settle();
    do @(negedge clk);
    while (pend_q.size() != 0 || s_tvalid || owed != 0 || m_tvalid);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_timeout(input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    idle_limit  = v;
    timeout_now = int'(v);
  endtask

  // Stimulus sequence
  initial begin
    timeout_now = int'(TIMEOUT_RESET);
    repeat (RESET_TICKS) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: idle tick, ok frame, bad frame, timeout with one byte in
    add_ticks(1);
    add_item(CMD_BYTE, 8'h00);
    add_item(CMD_BYTE, 8'h03);
    add_item(CMD_BYTE, 8'hFF);
    add_item(CMD_BYTE, 8'hFF);
    add_item(CMD_BYTE, 8'h03);
    add_item(CMD_BYTE, 8'hFF);
    add_item(CMD_BYTE, 8'h04);
    add_item(CMD_BYTE, 8'h00);
    add_item(CMD_BYTE, 8'h00);
    add_item(CMD_BYTE, 8'h5A);
    add_item(CMD_BYTE, 8'h00);
    add_item(CMD_BYTE, 8'h77);
    add_ticks(11);
    add_random_traffic(60);
    next_drains = 1'b1;
    add_random_traffic(66);
    settle();

    // timeout of one, idling swapped
    set_timeout(8'd1);
    send_idle_pct = 58;
    recv_idle_pct = 33;
    add_item(CMD_BYTE, 8'($urandom));
    add_ticks(2);
    add_random_traffic(150);
    settle();

    // longest timeout never fires; full-count overflow
    set_timeout(8'd255);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_ticks(3);
    add_overflow_run();
    add_random_traffic(30);
    settle();

    set_timeout(8'($urandom_range(2, 40)));
    add_random_traffic(100);
    settle();

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ibus_frame_receiver_top: match");
    end else begin
      $display("ibus_frame_receiver_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * CLK_HALF * 300000);
    $display("ibus_frame_receiver_top: mismatch");
    $finish;
  end

endmodule

>>> ibus_frame_receiver_top.f
+incdir+rtl
rtl/ifr_pkg.sv
rtl/ifr_frame_logic.sv
rtl/ibus_frame_receiver_top.sv
tb/tb_ibus_frame_receiver_top.sv
